>>> hw/rtl/max_product_path_tree_assert.svh
// assertion helpers for the max product path tree
`ifndef MAX_PRODUCT_PATH_TREE_ASSERT_SVH
`define MAX_PRODUCT_PATH_TREE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define MPTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define MPTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mptt_pkg.sv
`timescale 1ns / 1ps

package mptt_pkg;

  // default node capacity
  localparam int DefaultMaxNodes = 32;

  // request codes
  localparam logic [1:0] ReqNode = 2'd0;
  localparam logic [1:0] ReqLink = 2'd1;
  localparam logic [1:0] ReqRun  = 2'd2;

  // percent scale and hop saturation
  localparam logic [6:0] FullPct = 7'd100;
  localparam logic [4:0] HopMax  = 5'd31;

  // floor(x / 100) as (x * 5243) >> 19, exact for x below 43690
  localparam logic [12:0] RecipPct   = 13'd5243;
  localparam int          RecipShift = 19;

  // input transaction
  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] node_index;
    logic [4:0] peer_index;
    logic [6:0] value;
    logic       is_known;
    logic [5:0] node_count;
  } mptt_req_t;

  // result transaction
  typedef struct packed {
    logic [4:0] out_node;
    logic [6:0] path_metric;
    logic [4:0] parent_node;
    logic [4:0] hop_depth;
    logic       via_root;
    logic       candidate;
    logic       last;
  } mptt_res_t;

  // limit a loaded percentage to 100
  function automatic logic [6:0] clamp_pct(input logic [6:0] v);
    return (v > FullPct) ? FullPct : v;
  endfunction

endpackage

>>> hw/rtl/mptt_ram.sv
`timescale 1ns / 1ps

module mptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/max_product_path_tree.sv
// Greedy max-product path tree. Node entries (req_type node) and link ratio entries
// (req_type link) never raise busy. A run item (req_type run, node_count N) raises
// busy until the tree is built and all N results have been launched. Every build step
// scans the ratio matrix with one 7x7 multiplier and one comparator fed by the single
// read port of the ratio memory, one pair per cycle along each source row. Results are
// read from the node memory and then registered onto res_o, each marked by strobe_o for
// exactly one cycle; the receiver cannot stall them, so it must take every strobed
// result. The final result of a run has last set and is on the ports in the first
// cycle with busy low, so the next transaction may be accepted at the edge that ends it.
`timescale 1ns / 1ps

`include "max_product_path_tree_assert.svh"

module max_product_path_tree import mptt_pkg::*; #(
  parameter int MAX_NODES = DefaultMaxNodes
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  mptt_req_t req_i,
  output logic      strobe_o,
  output mptt_res_t res_o
);

  localparam int IW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int RAW = 2 * IW;
  localparam int RatioDepth = 1 << RAW;
  localparam logic [CW-1:0] NMax = CW'(MAX_NODES);

  typedef struct packed {
    logic [6:0]    metric;
    logic [IW-1:0] parent;
    logic [4:0]    hop;
  } node_word_t;

  localparam int NW = $bits(node_word_t);

  typedef enum logic [3:0] {
    StIdle,
    StStep,
    StSrc,
    StSrcWait,
    StDst,
    StAttachRd,
    StAttachWr,
    StEmitRd,
    StEmitOut
  } state_e;

  state_e           state_q;
  logic [CW-1:0]    n_q, step_q, s_q, d_q, i_q;
  logic [6:0]       metric_q, quot_q;
  logic             pend_q, found_q, rd_vld_q, strobe_q;
  logic [IW-1:0]    pend_d_q, best_s_q, best_d_q;
  logic [13:0]      best_q;
  logic [MAX_NODES-1:0] in_tree_q, root_q, node_vld_q;
  mptt_res_t        res_q;

  logic             accept;
  logic             node_ok, peer_ok;
  logic [IW-1:0]    node_idx, peer_idx;
  logic [6:0]       metric_in;
  logic [CW-1:0]    n_run;
  logic             node_we, ratio_we;
  logic [IW-1:0]    node_waddr, node_raddr;
  node_word_t       node_wdata, node_rdata, node_rd;
  logic [RAW-1:0]   ratio_waddr, ratio_raddr;
  logic [6:0]       ratio_wdata, ratio_rdata;
  logic [13:0]      prod;
  logic             take, elig;
  logic [4:0]       hop_inc;
  logic [26:0]      quot_full;

  // request decode
  always_comb begin
    accept    = start && (state_q == StIdle);
    node_ok   = 32'(req_i.node_index) < MAX_NODES;
    peer_ok   = 32'(req_i.peer_index) < MAX_NODES;
    node_idx  = IW'(req_i.node_index);
    peer_idx  = IW'(req_i.peer_index);
    n_run     = (32'(req_i.node_count) > MAX_NODES) ? NMax : CW'(req_i.node_count);
    if (req_i.is_known) begin
      metric_in = FullPct;
    end else if (req_i.node_index == 5'd0) begin
      metric_in = clamp_pct(req_i.value);
    end else begin
      metric_in = 7'd0;
    end
  end

  // an entry never loaded reads as the reset value
  assign node_rd = rd_vld_q ? node_rdata : '0;

  // shared product and compare unit
  always_comb begin
    prod    = 14'(metric_q) * 14'(ratio_rdata);
    take    = pend_q && (!found_q || (prod >= best_q));
    elig    = (d_q < n_q) && (d_q != s_q) && !in_tree_q[d_q[IW-1:0]];
    hop_inc = (node_rd.hop >= HopMax) ? HopMax : node_rd.hop + 5'd1;
    quot_full = 27'(best_q) * 27'(RecipPct);
  end

  // node memory ports
  always_comb begin
    node_we    = 1'b0;
    node_waddr = node_idx;
    node_wdata = '{metric: metric_in, parent: node_idx, hop: 5'd0};
    if (accept && (req_i.req_type == ReqNode) && node_ok) begin
      node_we = 1'b1;
    end else if (state_q == StAttachWr) begin
      node_we    = 1'b1;
      node_waddr = best_d_q;
      node_wdata = '{metric: quot_q, parent: best_s_q, hop: hop_inc};
    end
    unique case (state_q)
      StSrc:      node_raddr = s_q[IW-1:0];
      StAttachRd: node_raddr = best_s_q;
      StEmitRd:   node_raddr = i_q[IW-1:0];
      default:    node_raddr = '0;
    endcase
  end

  // ratio memory ports
  always_comb begin
    ratio_we    = accept && (req_i.req_type == ReqLink) && node_ok && peer_ok;
    ratio_waddr = {node_idx, peer_idx};
    ratio_wdata = clamp_pct(req_i.value);
    ratio_raddr = {s_q[IW-1:0], d_q[IW-1:0]};
  end

  mptt_ram #(
    .WIDTH(NW),
    .DEPTH(MAX_NODES)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (node_we),
    .waddr_i(node_waddr),
    .wdata_i(node_wdata),
    .raddr_i(node_raddr),
    .rdata_o(node_rdata)
  );

  mptt_ram #(
    .WIDTH(7),
    .DEPTH(RatioDepth)
  ) u_ratio_ram (
    .clk_i  (clk_i),
    .we_i   (ratio_we),
    .waddr_i(ratio_waddr),
    .wdata_i(ratio_wdata),
    .raddr_i(ratio_raddr),
    .rdata_o(ratio_rdata)
  );

  // sequencer, tree flags and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      strobe_q   <= 1'b0;
      pend_q     <= 1'b0;
      found_q    <= 1'b0;
      rd_vld_q   <= 1'b0;
      in_tree_q  <= '0;
      root_q     <= '0;
      node_vld_q <= '0;
      n_q        <= '0;
      step_q     <= '0;
      s_q        <= '0;
      d_q        <= '0;
      i_q        <= '0;
      metric_q   <= '0;
      quot_q     <= '0;
      best_q     <= '0;
      best_s_q   <= '0;
      best_d_q   <= '0;
      pend_d_q   <= '0;
      res_q      <= '0;
    end else begin
      strobe_q <= 1'b0;
      pend_q   <= 1'b0;
      rd_vld_q <= node_vld_q[node_raddr];

      // keep the best pair, ties go to the later one
      if (take) begin
        found_q  <= 1'b1;
        best_q   <= prod;
        best_s_q <= s_q[IW-1:0];
        best_d_q <= pend_d_q;
      end

      unique case (state_q)
        StIdle: begin
          if (accept) begin
            case (req_i.req_type)
              ReqNode: begin
                if (node_ok) begin
                  node_vld_q[node_idx] <= 1'b1;
                  in_tree_q[node_idx]  <= req_i.is_known || (node_idx == '0);
                  root_q[node_idx]     <= (node_idx == '0);
                end
              end
              ReqRun: begin
                if (req_i.node_count != 6'd0) begin
                  n_q          <= n_run;
                  in_tree_q[0] <= 1'b1;
                  root_q[0]    <= 1'b1;
                  step_q       <= '0;
                  state_q      <= StStep;
                end
              end
              default: ;
            endcase
          end
        end
        StStep: begin
          s_q     <= '0;
          found_q <= 1'b0;
          state_q <= StSrc;
        end
        StSrc: begin
          if (s_q == n_q) begin
            if (found_q) begin
              state_q <= StAttachRd;
            end else begin
              i_q     <= '0;
              state_q <= StEmitRd;
            end
          end else if (in_tree_q[s_q[IW-1:0]]) begin
            state_q <= StSrcWait;
          end else begin
            s_q <= s_q + CW'(1);
          end
        end
        StSrcWait: begin
          metric_q <= node_rd.metric;
          d_q      <= '0;
          state_q  <= StDst;
        end
        StDst: begin
          if (d_q == n_q) begin
            s_q     <= s_q + CW'(1);
            state_q <= StSrc;
          end else begin
            if (elig) begin
              pend_q   <= 1'b1;
              pend_d_q <= d_q[IW-1:0];
            end
            d_q <= d_q + CW'(1);
          end
        end
        StAttachRd: begin
          quot_q  <= 7'(quot_full >> RecipShift);
          state_q <= StAttachWr;
        end
        StAttachWr: begin
          in_tree_q[best_d_q]  <= 1'b1;
          node_vld_q[best_d_q] <= 1'b1;
          root_q[best_d_q]     <= root_q[best_s_q];
          step_q               <= step_q + CW'(1);
          if ((step_q + CW'(1)) == n_q) begin
            i_q     <= '0;
            state_q <= StEmitRd;
          end else begin
            state_q <= StStep;
          end
        end
        StEmitRd: begin
          state_q <= StEmitOut;
        end
        StEmitOut: begin
          strobe_q          <= 1'b1;
          res_q.out_node    <= 5'(i_q);
          res_q.path_metric <= node_rd.metric;
          res_q.parent_node <= 5'(node_rd.parent);
          res_q.hop_depth   <= node_rd.hop;
          res_q.via_root    <= root_q[i_q[IW-1:0]];
          res_q.candidate   <= root_q[i_q[IW-1:0]] && (node_rd.hop == 5'd1);
          res_q.last        <= (i_q + CW'(1)) == n_q;
          i_q               <= i_q + CW'(1);
          if ((i_q + CW'(1)) == n_q) begin
            state_q <= StIdle;
          end else begin
            state_q <= StEmitRd;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy     = (state_q != StIdle);
  assign strobe_o = strobe_q;
  assign res_o    = res_q;

  // checks
  logic          attach_wr, attach_cross;
  logic [CW-1:0] tree_size, tree_next;

  assign attach_wr    = (state_q == StAttachWr);
  assign attach_cross = !in_tree_q[best_d_q] && in_tree_q[best_s_q];
  assign tree_size    = CW'($countones(in_tree_q));
  assign tree_next    = tree_size + CW'(1);

  `MPTT_ASSERT_IMP(a_root_held, busy, in_tree_q[0] && root_q[0], "root not in tree during run")
  `MPTT_ASSERT_IMP(a_attach_edge, attach_wr, attach_cross, "bad attach pair")
  `MPTT_ASSERT_NXT(a_tree_grows, attach_wr, tree_size == $past(tree_next), "tree did not grow")
  `MPTT_ASSERT_IMP(a_last_frees, strobe_o, busy == !res_o.last, "busy out of step with last")
  `MPTT_ASSERT_IMP(a_pend_in_scan, pend_q, state_q == StDst, "compare pending outside scan")

endmodule

>>> tb/max_product_path_tree_tb.sv
`timescale 1ns / 1ps

module max_product_path_tree_tb;
  import mptt_pkg::*;

  localparam int NODES        = DefaultMaxNodes;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 220;
  localparam int ReqBits      = $bits(mptt_req_t);

  // request code the block must ignore
  localparam logic [1:0] ReqSpare = 2'd3;

  // mirror of the tree builder plus the queue of node results still owed
  class tree_scoreboard;
    logic [6:0] metric [NODES];
    logic [4:0] parent [NODES];
    logic [4:0] hops [NODES];
    bit         attached [NODES];
    bit         from_root [NODES];
    logic [6:0] ratio [NODES][NODES];
    mptt_res_t  pending_nodes [$];
    int         fails;
    int         checked;
    int         runs;

    function new();
      int i;
      int j;
      for (i = 0; i < NODES; i++) begin
        metric[i] = '0;
        parent[i] = '0;
        hops[i] = '0;
        attached[i] = 1'b0;
        from_root[i] = 1'b0;
        for (j = 0; j < NODES; j++) ratio[i][j] = '0;
      end
      fails = 0;
      checked = 0;
      runs = 0;
    endfunction

    // greedy growth: best source metric * ratio, ties to the last pair scanned
    function void attach_nodes(int n);
      int step;
      int s;
      int d;
      int prod;
      int best;
      int bs;
      int bd;
      bit found;
      for (step = 0; step < n; step++) begin
        found = 1'b0;
        best = 0;
        bs = 0;
        bd = 0;
        for (s = 0; s < n; s++) begin
          if (!attached[s]) continue;
          for (d = 0; d < n; d++) begin
            if (d == s || attached[d]) continue;
            prod = int'(metric[s]) * int'(ratio[s][d]);
            if (!found || prod >= best) begin
              found = 1'b1;
              best = prod;
              bs = s;
              bd = d;
            end
          end
        end
        if (!found) return;
        metric[bd] = 7'(best / int'(FullPct));
        parent[bd] = 5'(bs);
        hops[bd] = (hops[bs] >= HopMax) ? HopMax : hops[bs] + 5'd1;
        from_root[bd] = from_root[bs];
        attached[bd] = 1'b1;
      end
    endfunction

    // update the mirror for one accepted transaction
    function void note_request(mptt_req_t r);
      int n;
      int i;
      logic [6:0] pct;
      mptt_res_t res;
      pct = (r.value > FullPct) ? FullPct : r.value;
      case (r.req_type)
        ReqNode: begin
          if (r.is_known) metric[r.node_index] = FullPct;
          else if (r.node_index == 0) metric[r.node_index] = pct;
          else metric[r.node_index] = '0;
          parent[r.node_index] = r.node_index;
          hops[r.node_index] = '0;
          attached[r.node_index] = r.is_known || (r.node_index == 0);
          from_root[r.node_index] = (r.node_index == 0);
        end
        ReqLink: begin
          ratio[r.node_index][r.peer_index] = pct;
        end
        ReqRun: begin
          if (r.node_count != 0) begin
            n = (r.node_count > NODES) ? NODES : int'(r.node_count);
            attached[0] = 1'b1;
            from_root[0] = 1'b1;
            parent[0] = '0;
            attach_nodes(n);
            for (i = 0; i < n; i++) begin
              res.out_node = 5'(i);
              res.path_metric = metric[i];
              res.parent_node = parent[i];
              res.hop_depth = hops[i];
              res.via_root = from_root[i];
              res.candidate = from_root[i] && (hops[i] == 5'd1);
              res.last = (i + 1 == n);
              pending_nodes.insert(pending_nodes.size(), res);
            end
            runs++;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, logic [6:0] want, logic [6:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        fails++;
      end
    endfunction

    // match one strobed result against the oldest expectation
    function void check_result(mptt_res_t got);
      mptt_res_t want;
      if (pending_nodes.size() == 0) begin
        $error("result for node %0d arrived with nothing pending", got.out_node);
        fails++;
        return;
      end
      want = pending_nodes.pop_front();
      checked++;
      compare("out_node", 7'(want.out_node), 7'(got.out_node));
      compare("path_metric", want.path_metric, got.path_metric);
      compare("parent_node", 7'(want.parent_node), 7'(got.parent_node));
      compare("hop_depth", 7'(want.hop_depth), 7'(got.hop_depth));
      compare("via_root", 7'(want.via_root), 7'(got.via_root));
      compare("candidate", 7'(want.candidate), 7'(got.candidate));
      compare("last", 7'(want.last), 7'(got.last));
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  mptt_req_t req_i = '0;
  logic      busy;
  logic      strobe_o;
  mptt_res_t res_o;

  tree_scoreboard board = new();
  bit ratio_loaded [NODES][NODES];
  bit quiet;
  int sent_items;
  int sent_total;
  int cycles;

  max_product_path_tree DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .strobe_o (strobe_o),
    .res_o    (res_o)
  );

  always #4 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // accepted input transactions
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) board.note_request(req_i);
  end

  // strobed result transactions
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) board.check_result(res_o);
  end

  // present one transaction after a random gap and hold it until accepted
  task automatic send(input mptt_req_t r);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (r.req_type == ReqLink) ratio_loaded[r.node_index][r.peer_index] = 1'b1;
    if (r.req_type == ReqNode || r.req_type == ReqLink ||
        (r.req_type == ReqRun && r.node_count != 0)) sent_items++;
    sent_total++;
  endtask

  task automatic send_node(input int idx, input int val, input bit known);
    mptt_req_t r;
    r = mptt_req_t'(ReqBits'($urandom));
    r.req_type = ReqNode;
    r.node_index = 5'(idx);
    r.value = 7'(val);
    r.is_known = known;
    send(r);
  endtask

  task automatic send_link(input int src, input int dst, input int val);
    mptt_req_t r;
    r = mptt_req_t'(ReqBits'($urandom));
    r.req_type = ReqLink;
    r.node_index = 5'(src);
    r.peer_index = 5'(dst);
    r.value = 7'(val);
    send(r);
  endtask

  task automatic send_run(input int count);
    mptt_req_t r;
    r = mptt_req_t'(ReqBits'($urandom));
    r.req_type = ReqRun;
    r.node_count = 6'(count);
    send(r);
  endtask

  task automatic send_spare();
    mptt_req_t r;
    r = mptt_req_t'(ReqBits'($urandom));
    r.req_type = ReqSpare;
    send(r);
  endtask

  function automatic int rand_ratio();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 100;
      2: return $urandom_range(101, 127);
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  // every ratio a run of n nodes can read must have been written
  task automatic fill_links(input int n);
    int s;
    int d;
    for (s = 0; s < n; s++) begin
      for (d = 0; d < n; d++) begin
        if (s != d && !ratio_loaded[s][d]) send_link(s, d, rand_ratio());
      end
    end
  endtask

  // hold off the sender until all owed results are in
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending_nodes.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int i;
    int n;
    bit partial;

    quiet = 1'b0;
    sent_items = 0;
    sent_total = 0;
    cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // root never loaded: metric zero, every product ties at zero
    send_link(0, 1, 127);
    send_link(0, 2, 0);
    send_link(1, 0, 55);
    send_link(1, 2, 100);
    send_link(2, 0, 1);
    send_link(2, 1, 64);
    send_run(3);

    // zero node count and an unused request code
    send_run(0);
    send_spare();

    // clamped root metric, a known neighbor, repeated run
    send_node(0, 127, 1'b0);
    send_node(1, 0, 1'b1);
    send_node(2, 99, 1'b0);
    send_node(3, 127, 1'b0);
    send_link(0, 3, 100);
    send_link(1, 3, 100);
    send_link(3, 2, 127);
    fill_links(4);
    send_run(4);
    send_run(4);

    // known root keeps metric 100
    send_node(0, 7, 1'b1);
    send_node(1, 0, 1'b0);
    send_node(2, 0, 1'b0);
    send_node(3, 0, 1'b0);
    send_run(4);
    drain_results();

    // every other node known, so a full-size run reads no ratio;
    // node count above capacity saturates
    quiet = 1'b1;
    for (i = 0; i < NODES; i++) send_node(i, (i == 0) ? 88 : 0, i != 0);
    quiet = 1'b0;
    send_run(63);
    send_run(NODES);

    // random trees over the first few nodes
    while (sent_items < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 8);
      if ($urandom_range(0, 4) == 0) drain_results();

      // node entries, sometimes only a few so earlier tree parts survive
      partial = ($urandom_range(0, 4) == 0);
      for (i = 0; i < n; i++) begin
        if (!partial || $urandom_range(0, 1) == 1) begin
          if (i == 0)
            send_node(0, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(40, 100),
                      $urandom_range(0, 7) == 0);
          else
            send_node(i, $urandom_range(0, 127), $urandom_range(0, 6) == 0);
        end
      end

      // random ratios, mostly inside the active nodes
      repeat ($urandom_range(0, n)) begin
        if ($urandom_range(0, 5) == 0)
          send_link($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
                    rand_ratio());
        else
          send_link($urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_ratio());
      end
      fill_links(n);

      // noise
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1) == 1) send_spare();
        else send_run(0);
      end

      send_run(n);
      if ($urandom_range(0, 5) == 0) send_run(n);
    end
    start <= 1'b0;

    // wait for everything owed, then a short tail
    @(posedge clk_i);
    while (board.pending_nodes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("sent %0d requests, %0d tree runs, %0d node results checked",
             sent_total, board.runs, board.checked);
    $display("covered clamping, known nodes, unloaded root, oversized node count, idle codes");
    if (board.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mptt_pkg.sv
hw/rtl/mptt_ram.sv
hw/rtl/max_product_path_tree.sv
tb/max_product_path_tree_tb.sv
